// File: src/dsb_pkg.sv
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared types, constants and lane arithmetic for the 3:2 box downscaler.
// ----------------------------------------------------------------------------
package dsb_pkg;

    // source line width in pixels (3 or more)
    localparam int SRC_WIDTH = 1920;
    localparam int COL_W     = $clog2(SRC_WIDTH);
    localparam int PIX_W     = 32;
    localparam int LANE_W    = 8;
    localparam int LANES     = PIX_W / LANE_W;

    // phase within a group of three rows or columns
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } phase_t;

    // per-item context carried from the address stage to the average stage
    typedef struct packed {
        logic [PIX_W-1:0] cur;
        phase_t           row_ph;
        phase_t           col_ph;
        logic             last;
    } stage_t;

    // per-lane truncated mean of four pixels
    function automatic logic [PIX_W-1:0] mean4(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] d
    );
        logic [PIX_W-1:0]  res;
        logic [LANE_W+1:0] sum;
        res = '0;
        for (int i = 0; i < LANES; i++) begin
            sum = {2'b00, a[i*LANE_W +: LANE_W]} + {2'b00, b[i*LANE_W +: LANE_W]}
                + {2'b00, c[i*LANE_W +: LANE_W]} + {2'b00, d[i*LANE_W +: LANE_W]};
            res[i*LANE_W +: LANE_W] = sum[LANE_W+1:2];
        end
        return res;
    endfunction

endpackage

// File: src/dsb_line_ram.sv
// ----------------------------------------------------------------------------
// dsb_line_ram
// One-line pixel store, single address, registered read data.
// ----------------------------------------------------------------------------
module dsb_line_ram (
    input  logic                        aclk,
    input  logic                        we,     // write pixel at addr
    input  logic                        re,     // read pixel at addr
    input  logic [dsb_pkg::COL_W-1:0]   addr,
    input  logic [dsb_pkg::PIX_W-1:0]   wdata,
    output logic [dsb_pkg::PIX_W-1:0]   rdata
);
    import dsb_pkg::*;

    logic [PIX_W-1:0] mem [SRC_WIDTH];
    logic [PIX_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/downscale_three_to_two_box_unit.sv
// ----------------------------------------------------------------------------
// downscale_three_to_two_box_unit
// 3:2 box-filter downscaler for a raster stream of four-lane 8-bit pixels.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata              | side band
//  ---------+-----+--------------------+-------------------------
//  s_       | in  | pixel_in [31:0]    | tuser: frame_start
//  m_       | out | pixel_out [31:0]   | tlast: line_last
//
//  one item accepted per cycle while s_tready is high; each result passes the stage register, then the output register
//  two stages: line store address/write, then store read data and lane average
//  reset (aresetn low, synchronous) empties the pipe and zeroes the phases
//  the line store needs no clearing pass; each entry is written before use
//  a stalled output register holds back the average stage and then s_tready
// ----------------------------------------------------------------------------
module downscale_three_to_two_box_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [dsb_pkg::PIX_W-1:0] s_tdata,   // [31:0] pixel_in
    input  logic                      s_tuser,   // [0] frame_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [dsb_pkg::PIX_W-1:0] m_tdata,   // [31:0] pixel_out
    output logic                      m_tlast    // line_last
);
    import dsb_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    phase_t           col_ph_reg, col_ph_next;
    phase_t           row_ph_reg, row_ph_next;
    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_reg;
    logic [PIX_W-1:0] held_pix_reg;
    logic [PIX_W-1:0] held_up_reg;
    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;

    logic             accept;
    logic [COL_W-1:0] col_eff;
    phase_t           col_ph_eff;
    phase_t           row_ph_eff;
    logic             last0;
    logic [PIX_W-1:0] ram_q;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] result;
    logic             s1_emit;
    logic             s1_adv;

    assign accept = s_tvalid && s_tready;

    // position of the incoming item, frame start realigns to the origin
    always_comb begin
        col_eff    = s_tuser ? '0   : col_reg;
        col_ph_eff = s_tuser ? PH_0 : col_ph_reg;
        row_ph_eff = s_tuser ? PH_0 : row_ph_reg;
        last0      = (col_eff == COL_W'(SRC_WIDTH - 1));
    end

    // next position
    always_comb begin
        col_next    = col_reg;
        col_ph_next = col_ph_reg;
        row_ph_next = row_ph_reg;
        if (accept) begin
            if (last0) begin
                col_next    = '0;
                col_ph_next = PH_0;
                row_ph_next = (row_ph_eff == PH_2) ? PH_0 : phase_t'(row_ph_eff + 2'd1);
            end else begin
                col_next    = col_eff + COL_W'(1);
                col_ph_next = (col_ph_eff == PH_2) ? PH_0 : phase_t'(col_ph_eff + 2'd1);
                row_ph_next = row_ph_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            col_ph_reg <= PH_0;
            row_ph_reg <= PH_0;
        end else begin
            col_reg    <= col_next;
            col_ph_reg <= col_ph_next;
            row_ph_reg <= row_ph_next;
        end
    end

    // line store: row phase 1 writes, other phases read
    dsb_line_ram u_line_ram (
        .aclk  (aclk),
        .we    (accept && (row_ph_eff == PH_1)),
        .re    (accept && (row_ph_eff != PH_1)),
        .addr  (col_eff),
        .wdata (s_tdata),
        .rdata (ram_q)
    );

    // average stage
    always_comb begin
        up      = (s1_reg.row_ph == PH_2) ? ram_q : s1_reg.cur;
        result  = '0;
        s1_emit = 1'b0;
        if (s1_valid_reg && (s1_reg.row_ph != PH_1)) begin
            unique case (s1_reg.col_ph)
                PH_0: begin
                    result  = mean4(up, up, s1_reg.cur, s1_reg.cur);
                    s1_emit = 1'b1;
                end
                PH_1: begin
                    result  = mean4(up, up, s1_reg.cur, s1_reg.cur);
                    s1_emit = s1_reg.last;
                end
                PH_2: begin
                    result  = mean4(held_up_reg, up, held_pix_reg, s1_reg.cur);
                    s1_emit = 1'b1;
                end
                default: begin
                    result  = '0;
                    s1_emit = 1'b0;
                end
            endcase
        end
    end

    assign s1_adv   = s1_valid_reg && (!s1_emit || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg.cur    <= s_tdata;
            s1_reg.row_ph <= row_ph_eff;
            s1_reg.col_ph <= col_ph_eff;
            s1_reg.last   <= last0;
        end
    end

    // column phase 1 pixels held for the pair average
    always_ff @(posedge aclk) begin
        if (s1_adv && (s1_reg.row_ph != PH_1) && (s1_reg.col_ph == PH_1)) begin
            held_pix_reg <= s1_reg.cur;
            held_up_reg  <= up;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv && s1_emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit) begin
            m_data_reg <= result;
            m_last_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: tb/downscale_three_to_two_box_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downscale_three_to_two_box_unit_tb
// Self-checking bench for the 3:2 box downscaler. A small scoreboard keeps
// its own copy of the phases, the held pixels and the line store, predicts
// every scaled pixel from the accepted source items, and compares each
// output item in order. Stimulus is a short directed run, then one long run
// from a frame start past the end of a source row, with random idling on
// both sides, a stretch with no idling and long output stalls.
// ----------------------------------------------------------------------------
module downscale_three_to_two_box_unit_tb;

    import dsb_pkg::*;

    // scoreboard: source items in, predicted scaled pixels out
    class dsb_scoreboard;
        int unsigned      col_idx;
        phase_t           col_ph;
        phase_t           row_ph;
        logic [PIX_W-1:0] held_pix;
        logic [PIX_W-1:0] held_up;
        logic [PIX_W-1:0] line_mem [SRC_WIDTH];
        bit               line_written [SRC_WIDTH];
        logic [PIX_W-1:0] scaled_q [$];
        logic             row_end_q [$];
        int               errors;

        function new();
            col_idx  = 0;
            col_ph   = PH_0;
            row_ph   = PH_0;
            held_pix = '0;
            held_up  = '0;
            errors   = 0;
            for (int i = 0; i < SRC_WIDTH; i++) begin
                line_mem[i]     = '0;
                line_written[i] = 1'b0;
            end
        endfunction

        // per-lane truncated mean of four pixels
        function logic [PIX_W-1:0] box_mean(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                            logic [PIX_W-1:0] c, logic [PIX_W-1:0] d);
            logic [PIX_W-1:0] avg;
            logic [9:0]       total;
            avg = '0;
            for (int ln = 0; ln < LANES; ln++) begin
                total = 10'(a[ln*8 +: 8]) + 10'(b[ln*8 +: 8])
                      + 10'(c[ln*8 +: 8]) + 10'(d[ln*8 +: 8]);
                avg[ln*8 +: 8] = total[9:2];
            end
            return avg;
        endfunction

        // true when an item without frame start would read a line store entry never filled
        function bit would_read_blank();
            int unsigned col;
            col = (col_idx >= SRC_WIDTH) ? 0 : col_idx;
            return (row_ph == PH_2) && !line_written[col];
        endfunction

        function int pending();
            return scaled_q.size();
        endfunction

        // accepted source item: advance the phases, queue the scaled pixel if one is due
        function void note_source(logic [PIX_W-1:0] pix, logic fs);
            logic [PIX_W-1:0] up;
            logic [PIX_W-1:0] avg;
            bit               at_end;
            bit               emit;
            emit = 1'b0;
            avg  = '0;
            if (fs) begin
                col_idx = 0;
                col_ph  = PH_0;
                row_ph  = PH_0;
            end
            if (col_idx >= SRC_WIDTH)
                col_idx = 0;
            at_end = (col_idx == SRC_WIDTH - 1);
            if (row_ph == PH_1) begin
                // middle row of a group only fills the line store
                line_mem[col_idx]     = pix;
                line_written[col_idx] = 1'b1;
            end else begin
                // first row of a group pairs with itself, last row with the line store
                up = (row_ph == PH_2) ? line_mem[col_idx] : pix;
                case (col_ph)
                    PH_0: begin
                        avg  = box_mean(up, up, pix, pix);
                        emit = 1'b1;
                    end
                    PH_1: begin
                        held_pix = pix;
                        held_up  = up;
                        // row ending mid group: missing column clamped to this one
                        if (at_end) begin
                            avg  = box_mean(up, up, pix, pix);
                            emit = 1'b1;
                        end
                    end
                    default: begin
                        avg  = box_mean(held_up, up, held_pix, pix);
                        emit = 1'b1;
                    end
                endcase
            end
            if (at_end) begin
                col_idx = 0;
                col_ph  = PH_0;
                row_ph  = (row_ph == PH_2) ? PH_0 : phase_t'(row_ph + 2'd1);
            end else begin
                col_idx = col_idx + 1;
                col_ph  = (col_ph == PH_2) ? PH_0 : phase_t'(col_ph + 2'd1);
            end
            if (emit) begin
                scaled_q.push_back(avg);
                row_end_q.push_back(at_end);
            end
        endfunction

        // accepted output item against the oldest prediction
        function void check_scaled(logic [PIX_W-1:0] pix, logic last);
            logic [PIX_W-1:0] exp_pix;
            logic             exp_last;
            if (scaled_q.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: unexpected output item pixel %h last %b",
                             $time, pix, last);
                return;
            end
            exp_pix  = scaled_q.pop_front();
            exp_last = row_end_q.pop_front();
            if (pix !== exp_pix) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: pixel_out mismatch, expected %h actual %h",
                             $time, exp_pix, pix);
            end
            if (last !== exp_last) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: line_last mismatch, expected %b actual %b",
                             $time, exp_last, last);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [PIX_W-1:0] s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [PIX_W-1:0] m_tdata;
    logic             m_tlast;

    dsb_scoreboard board;
    int            idle_pct;

    downscale_three_to_two_box_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] pixel_in
        .s_tuser  (s_tuser),   // [0] frame_start
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] pixel_out
        .m_tlast  (m_tlast)    // line_last
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // random pixel, biased towards lane extremes and small values
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return $urandom & 32'h0303_0303;
            3:       return $urandom | 32'hfcfc_fcfc;
            default: return $urandom;
        endcase
    endfunction

    // offer one item after random idle cycles, hold it until taken
    task automatic send_source(input logic [PIX_W-1:0] pix, input logic fs);
        logic start;
        start = fs;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        // restart the frame rather than read a line store entry never filled
        if (!start && board.would_read_blank())
            start = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        board.note_source(pix, start);
    endtask

    // frame start on the first item, then plain items
    task automatic send_run(input int n);
        for (int i = 0; i < n; i++)
            send_source(pick_pixel(), i == 0);
    endtask

    // plain items carrying on from the current position
    task automatic send_more(input int n);
        for (int i = 0; i < n; i++)
            send_source(pick_pixel(), 1'b0);
    endtask

    // output side: random back-pressure plus long hold-offs
    initial begin
        int unsigned cyc;
        int          hold;
        cyc  = 0;
        hold = 0;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            cyc++;
            if (cyc == 400 || cyc == 1500)
                hold = 600;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
            @(posedge aclk);
        end
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_scaled(m_tdata, m_tlast);
    end

    // overall time limit
    initial begin
        #6_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int wait_cnt;
        board    = new();
        idle_pct = 20;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: lane extremes, truncation, frame start on each column phase
        send_source(32'hffff_ffff, 1'b1);
        send_source(32'h0000_0000, 1'b0);
        send_source(32'hffff_ffff, 1'b0);
        send_source(32'h0102_0304, 1'b0);
        send_source(32'h0203_0405, 1'b0);
        send_source(32'h0101_0101, 1'b0);
        send_source(32'h80ff_007f, 1'b0);
        send_source(32'h7f00_ff80, 1'b0);
        send_source(32'hfffe_fdfc, 1'b0);
        send_source(32'h55aa_55aa, 1'b0);
        send_source(32'haa55_aa55, 1'b1);
        send_source(32'h1234_5678, 1'b0);
        send_source(32'h00ff_00ff, 1'b1);
        send_source(32'hff00_ff00, 1'b0);
        send_source(32'h0f0f_0f0f, 1'b0);
        send_source(32'hf0f0_f0f0, 1'b0);
        send_source(32'h0000_0000, 1'b0);
        send_source(32'hffff_ffff, 1'b0);

        // one source row from a frame start, with a stretch of no idling,
        // then a few items into the middle row of the group
        send_run(700);
        idle_pct = 0;
        send_more(600);
        idle_pct = 20;
        send_more(SRC_WIDTH - 1300 + 12);

        // drain
        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (board.pending() != 0 && wait_cnt < 10000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (20) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
